// ===== rtl/core/rse_pkg.sv =====
// Shared constants, codes and control types for the RPN stack evaluator.
package rse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int QUOT_W = DATA_W + FRAC_W;
  localparam int STEP_W = $clog2(QUOT_W);

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_END  = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_ZDIV    = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;
  localparam logic [2:0] ST_NONE    = 3'd5;

  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_TOP    = 2'd0;
  localparam rd_sel_t RD_SECOND = 2'd1;
  localparam rd_sel_t RD_BOTTOM = 2'd2;

  typedef logic [1:0] wb_sel_t;
  localparam wb_sel_t WB_ADDSUB = 2'd0;
  localparam wb_sel_t WB_MUL    = 2'd1;
  localparam wb_sel_t WB_DIV    = 2'd2;

  typedef struct packed {
    logic    load_token;
    logic    push;
    rd_sel_t rd_sel;
    logic    latch_right;
    logic    latch_left;
    logic    latch_prod;
    logic    div_start;
    logic    set_empty;
    logic    set_zdiv;
    logic    write_back;
    wb_sel_t wb_sel;
    logic    report;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sticky_ok;
    logic       lt2;
    logic       right_zero;
    logic       div_done;
  } stat_t;

endpackage

// ===== rtl/core/rse_divider.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module rse_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rse_pkg::QUOT_W-1:0] dividend,
  input  logic [rse_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [rse_pkg::QUOT_W-1:0] quotient
);
  import rse_pkg::*;

  logic              running;
  logic [STEP_W-1:0] steps;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvsr;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;
  logic              q_bit;

  always_comb begin
    shifted  = {rem, quotient[QUOT_W-1]};
    diff     = {1'b0, shifted} - {2'b00, dvsr};
    q_bit    = ~diff[DATA_W+1];
    rem_next = q_bit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        steps    <= STEP_W'(QUOT_W - 1);
        rem      <= '0;
        dvsr     <= divisor;
        quotient <= dividend;
      end else if (running) begin
        rem      <= rem_next;
        quotient <= {quotient[QUOT_W-2:0], q_bit};
        if (steps == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          steps <= steps - STEP_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/rse_datapath.sv =====
// Datapath: operand stack memory, count, sticky error, arithmetic and result words.
module rse_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          operation,
  input  logic signed [31:0]  operand,
  input  rse_pkg::cmd_t       cmd,
  output rse_pkg::stat_t      stat,
  output logic                done,
  output logic [2:0]          status,
  output logic signed [31:0]  answer
);
  import rse_pkg::*;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat_signed(input logic [QUOT_W-1:0] mag,
                                                   input logic neg);
    logic [DATA_W-1:0] res;
    if (neg) begin
      if (mag >= {{(QUOT_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}}) begin
        res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        res = ~mag[DATA_W-1:0] + DATA_W'(1);
      end
    end else if (mag > {{(QUOT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}}) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res = mag[DATA_W-1:0];
    end
    return res;
  endfunction

  logic [DATA_W-1:0]   mem [STACK_DEPTH];
  logic [DATA_W-1:0]   rdata;
  logic [2:0]          op_q;
  logic [DATA_W-1:0]   value_q;
  logic [CNT_W-1:0]    count;
  logic [2:0]          sticky;
  logic [DATA_W-1:0]   left;
  logic [DATA_W-1:0]   right;
  logic [2*DATA_W-1:0] prod;
  logic                neg;

  logic [CNT_W-1:0]    top_idx;
  logic [CNT_W-1:0]    sec_idx;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                mem_we;
  logic                full;
  logic [DATA_W:0]     sum;
  logic [DATA_W-1:0]   addsub_res;
  logic [2*DATA_W-1:0] prod_adj;
  logic [DATA_W-1:0]   mul_res;
  logic [DATA_W-1:0]   div_res;
  logic [2:0]          end_status;
  logic                div_done;
  logic [QUOT_W-1:0]   quotient;

  rse_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({magnitude(left), {FRAC_W{1'b0}}}),
    .divisor  (magnitude(right)),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    top_idx = count - CNT_W'(1);
    sec_idx = count - CNT_W'(2);
    full    = (count == CNT_W'(STACK_DEPTH));

    unique case (cmd.rd_sel)
      RD_TOP:    rd_addr = top_idx[ADDR_W-1:0];
      RD_SECOND: rd_addr = sec_idx[ADDR_W-1:0];
      RD_BOTTOM: rd_addr = '0;
      default:   rd_addr = '0;
    endcase

    if (op_q == OP_SUB) begin
      sum = {left[DATA_W-1], left} - {right[DATA_W-1], right};
    end else begin
      sum = {left[DATA_W-1], left} + {right[DATA_W-1], right};
    end
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      addsub_res = {sum[DATA_W], {(DATA_W-1){~sum[DATA_W]}}};
    end else begin
      addsub_res = sum[DATA_W-1:0];
    end

    prod_adj = neg ? (prod + (2*DATA_W)'(16'hFFFF)) : prod;
    mul_res  = sat_signed(prod_adj[FRAC_W +: QUOT_W], neg);
    div_res  = sat_signed(quotient, neg);

    unique case (cmd.wb_sel)
      WB_ADDSUB: wr_data = addsub_res;
      WB_MUL:    wr_data = mul_res;
      WB_DIV:    wr_data = div_res;
      default:   wr_data = addsub_res;
    endcase
    if (cmd.push) begin
      wr_data = value_q;
      wr_addr = count[ADDR_W-1:0];
    end else begin
      wr_addr = sec_idx[ADDR_W-1:0];
    end
    mem_we = (cmd.push & ~full) | cmd.write_back;

    if (sticky != ST_OK) begin
      end_status = sticky;
    end else if (count == '0) begin
      end_status = ST_NONE;
    end else if (count != CNT_W'(1)) begin
      end_status = ST_INVALID;
    end else begin
      end_status = ST_OK;
    end

    stat.op         = op_q;
    stat.sticky_ok  = (sticky == ST_OK);
    stat.lt2        = (count < CNT_W'(2));
    stat.right_zero = (right == '0);
    stat.div_done   = div_done;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_token) begin
      op_q    <= operation;
      value_q <= operand;
    end
    if (cmd.latch_right) begin
      right <= rdata;
    end
    if (cmd.latch_left) begin
      left <= rdata;
    end
    if (cmd.latch_prod) begin
      prod <= (2*DATA_W)'(magnitude(left)) * (2*DATA_W)'(magnitude(right));
    end
    if (cmd.latch_prod | cmd.div_start) begin
      neg <= left[DATA_W-1] ^ right[DATA_W-1];
    end
    if (cmd.report) begin
      if (op_q == OP_END) begin
        status <= end_status;
        answer <= (end_status == ST_OK) ? rdata : '0;
      end else begin
        status <= sticky;
        answer <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sticky <= ST_OK;
      done   <= 1'b0;
    end else begin
      done <= cmd.report;
      if (cmd.push) begin
        if (full) begin
          sticky <= ST_FULL;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.set_empty) begin
        sticky <= ST_EMPTY;
      end
      if (cmd.set_zdiv) begin
        sticky <= ST_ZDIV;
      end
      if (cmd.write_back) begin
        count <= top_idx;
      end
      if (cmd.report && (op_q == OP_END)) begin
        count  <= '0;
        sticky <= ST_OK;
      end
    end
  end

endmodule

// ===== rtl/core/rse_ctrl.sv =====
// Controller state machine that sequences each token through the datapath.
module rse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rse_pkg::stat_t stat,
  output rse_pkg::cmd_t  cmd,
  output logic           busy
);
  import rse_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_READ_L  = 4'd2;
  localparam logic [3:0] S_LOAD_L  = 4'd3;
  localparam logic [3:0] S_EXEC    = 4'd4;
  localparam logic [3:0] S_MUL_WB  = 4'd5;
  localparam logic [3:0] S_DIV_RUN = 4'd6;
  localparam logic [3:0] S_DIV_WB  = 4'd7;
  localparam logic [3:0] S_REPORT  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_token = 1'b1;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_REPORT;
        if (stat.op == OP_END) begin
          cmd.rd_sel = RD_BOTTOM;
        end else if (stat.sticky_ok) begin
          if (stat.op == OP_PUSH) begin
            cmd.push = 1'b1;
          end else if (stat.op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
            if (stat.lt2) begin
              cmd.set_empty = 1'b1;
            end else begin
              cmd.rd_sel = RD_TOP;
              state_next = S_READ_L;
            end
          end
        end
      end
      S_READ_L: begin
        cmd.latch_right = 1'b1;
        cmd.rd_sel      = RD_SECOND;
        state_next      = S_LOAD_L;
      end
      S_LOAD_L: begin
        cmd.latch_left = 1'b1;
        state_next     = S_EXEC;
      end
      S_EXEC: begin
        case (stat.op)
          OP_MUL: begin
            cmd.latch_prod = 1'b1;
            state_next     = S_MUL_WB;
          end
          OP_DIV: begin
            if (stat.right_zero) begin
              cmd.set_zdiv = 1'b1;
              state_next   = S_REPORT;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV_RUN;
            end
          end
          default: begin
            cmd.write_back = 1'b1;
            cmd.wb_sel     = WB_ADDSUB;
            state_next     = S_REPORT;
          end
        endcase
      end
      S_MUL_WB: begin
        cmd.write_back = 1'b1;
        cmd.wb_sel     = WB_MUL;
        state_next     = S_REPORT;
      end
      S_DIV_RUN: begin
        if (stat.div_done) begin
          state_next = S_DIV_WB;
        end
      end
      S_DIV_WB: begin
        cmd.write_back = 1'b1;
        cmd.wb_sel     = WB_DIV;
        state_next     = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/rpn_stack_evaluator_core.sv =====
// Top level of the RPN stack evaluator: controller plus datapath.
//
//   channel   ports                          handshake
//   token     operation, operand             start & !busy at a rising edge
//   result    status, answer                 done, held for one cycle
//
// One result word per token. A push or an end token goes from decode to report;
// add and subtract read both operands and write back, multiply also latches the
// product, and divide waits on the bit-serial divider, one quotient bit a cycle.
// busy drops in the cycle that done is high, so the next token can follow.
// Synchronous reset clears the stack count, the sticky error and the sequencer.
// The receiver cannot stall; results are taken in the cycle they appear.
module rpn_stack_evaluator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [31:0] operand,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] answer
);
  import rse_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rse_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .operation (operation),
    .operand   (operand),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .status    (status),
    .answer    (answer)
  );

endmodule
